@@ hw/rtl/sobel_pkg.sv @@
// Shared types and constants for the Sobel edge magnitude and direction block.
`default_nettype none

package sobel_pkg;

  // Default and reset values of the block.
  localparam int DEFAULT_MAX_WIDTH = 2048;
  localparam int RESET_WIDTH       = 640;
  localparam int RESET_HEIGHT      = 480;

  // Sector thresholds: tan(22.5 deg) and tan(67.5 deg) with 16 fraction bits.
  localparam int unsigned TAN_LOW_Q16  = 27146;
  localparam int unsigned TAN_HIGH_Q16 = 158218;

  // Result queue geometry.
  localparam int FIFO_AW    = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_index_t;

  // Per-pixel bookkeeping that travels down the pipeline.
  typedef struct packed {
    logic        produce;
    logic        last;
    logic [10:0] column;
    logic [15:0] row;
  } tag_t;

  // One finished result beat.
  typedef struct packed {
    logic [7:0]        mag;
    logic signed [9:0] dir;
    logic [10:0]       column;
    logic [15:0]       row;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/sobel_edge_magnitude_direction.sv @@
// A result passes the line read, window, kernel sum and queue registers. Throughput: one
// pixel per cycle while in_ready is high, set by the line memory, which does one read and
// one write-back per cycle; a result queue lets pixels keep flowing while a result waits.
// Reset: counters and the 3x3 window clear, width and height return to 640 and 480.
// The line memory is not cleared; the rows it answers before being written are never used.
`default_nettype none

module sobel_edge_magnitude_direction #(
  parameter int MAX_WIDTH = sobel_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  // Pixel input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        red_sample,
  // Result output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        edge_magnitude,
  output logic signed [9:0] direction_deg,
  output logic [10:0]       out_column,
  output logic [15:0]       out_row,
  output logic              last_of_image
);
  import sobel_pkg::*;

  localparam int CCW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RESET_LAST_COL =
    ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

  // Configuration registers, kept as last column and last row.
  logic [CCW-1:0] last_col;
  logic [15:0]    last_row;
  logic [31:0]    width_raw;
  logic [CCW-1:0] last_col_next;
  logic [15:0]    last_row_next;
  logic           cfg_beat;

  assign cfg_ready = 1'b1;
  assign cfg_beat  = cfg_valid & cfg_ready;
  assign width_raw = {20'b0, cfg_data[11:0]};

  // Clamp the written width and height to their working range.
  always_comb begin
    if (width_raw < 32'd3) begin
      last_col_next = CCW'(2);
    end else if (width_raw > 32'(MAX_WIDTH)) begin
      last_col_next = CCW'(MAX_WIDTH - 1);
    end else begin
      last_col_next = CCW'(width_raw - 32'd1);
    end
    if (cfg_data < 16'd3) begin
      last_row_next = 16'd2;
    end else begin
      last_row_next = cfg_data - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= CCW'(RESET_LAST_COL);
      last_row <= 16'(RESET_HEIGHT - 1);
    end else if (cfg_beat) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  last_col <= last_col_next;
        CFG_IMAGE_HEIGHT: last_row <= last_row_next;
        default: ;
      endcase
    end
  end

  // Raster position of the next pixel.
  logic [CCW-1:0] col_count;
  logic [15:0]    row_count;
  logic           in_beat;
  logic [31:0]    col_minus1;
  tag_t           in_tag;

  assign in_beat    = in_valid & in_ready;
  assign col_minus1 = 32'(col_count) - 32'd1;

  always_comb begin
    in_tag.produce = (32'(col_count) >= 32'd2) && (row_count >= 16'd2) &&
                     (col_count <= last_col) && (row_count <= last_row);
    in_tag.last    = (col_count == last_col) && (row_count == last_row);
    in_tag.column  = col_minus1[10:0];
    in_tag.row     = row_count - 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_beat) begin
      if (col_count >= last_col) begin
        col_count <= '0;
        row_count <= (row_count >= last_row) ? 16'd0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + CCW'(1);
      end
    end
  end

  // Line memory: upper line in the high byte, middle line in the low byte.
  // Reads happen on the pixel beat, the write-back in the cycle after. The same
  // column is never touched again within three pixels, so no forwarding is needed.
  logic [15:0]    line_mem [MAX_WIDTH];
  logic [15:0]    line_rd;
  logic           s1_valid;
  logic [7:0]     s1_sample;
  logic [CCW-1:0] s1_col;
  tag_t           s1_tag;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      line_rd <= line_mem[col_count];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= {line_rd[7:0], s1_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_sample <= red_sample;
      s1_col    <= col_count;
      s1_tag    <= in_tag;
    end
  end

  // 3x3 window: shift one column left and take in the new column.
  logic [7:0] win [9];
  logic       s2_valid;
  tag_t       s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= line_rd[15:8];
      win[5] <= line_rd[7:0];
      win[8] <= s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_tag <= s1_tag;
  end

  // Kernel sums: A is bottom row minus top row, B is right column minus left.
  logic [9:0]         sum_top, sum_bot, sum_left, sum_right;
  logic signed [10:0] a_q, b_q;
  logic               s3_valid;
  tag_t               s3_tag;

  assign sum_top   = {2'b0, win[0]} + {1'b0, win[1], 1'b0} + {2'b0, win[2]};
  assign sum_bot   = {2'b0, win[6]} + {1'b0, win[7], 1'b0} + {2'b0, win[8]};
  assign sum_left  = {2'b0, win[0]} + {1'b0, win[3], 1'b0} + {2'b0, win[6]};
  assign sum_right = {2'b0, win[2]} + {1'b0, win[5], 1'b0} + {2'b0, win[8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    a_q    <= $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
    b_q    <= $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    s3_tag <= s2_tag;
  end

  // Magnitude and direction sector from the two sums.
  logic signed [10:0] a_negated, b_negated;
  logic [9:0]         ax, bx;
  logic [10:0]        abs_sum;
  logic [11:0]        abs_round;
  logic [27:0]        by_q16, ax_low, ax_high;
  logic [1:0]         sector;
  logic signed [3:0]  sector_s, k;
  logic signed [9:0]  k_wide, dir;
  res_t               res;

  assign a_negated = -a_q;
  assign b_negated = -b_q;
  assign ax        = a_q[10] ? a_negated[9:0] : a_q[9:0];
  assign bx        = b_q[10] ? b_negated[9:0] : b_q[9:0];
  assign abs_sum   = {1'b0, ax} + {1'b0, bx};
  assign abs_round = {1'b0, abs_sum} + 12'd2;
  assign by_q16    = {2'b0, bx, 16'b0};
  assign ax_low    = 28'(ax) * 28'(TAN_LOW_Q16);
  assign ax_high   = 28'(ax) * 28'(TAN_HIGH_Q16);

  always_comb begin
    if (by_q16 < ax_low) begin
      sector = 2'd0;
    end else if (by_q16 > ax_high) begin
      sector = 2'd2;
    end else begin
      sector = 2'd1;
    end
    sector_s = $signed({2'b00, sector});
    // Fold the first-quadrant sector into the quadrant of (A, B).
    if (!b_q[10]) begin
      k = a_q[10] ? (4'sd4 - sector_s) : sector_s;
    end else begin
      k = a_q[10] ? (sector_s - 4'sd4) : -sector_s;
    end
    k_wide = {{6{k[3]}}, k};
    if (a_q == 11'sd0 && b_q == 11'sd0) begin
      dir = 10'sd0;
    end else begin
      dir = k_wide * 10'sd45 - 10'sd90;
    end
    res.mag    = (abs_round[11:2] > 10'd255) ? 8'hFF : abs_round[9:2];
    res.dir    = dir;
    res.column = s3_tag.column;
    res.row    = s3_tag.row;
    res.last   = s3_tag.last;
  end

  // Result queue; pixels are admitted only while every in-flight pixel has a slot.
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   fifo_count;
  logic [FIFO_AW+1:0] credit_used;
  logic               push, pop;
  res_t               head;

  assign push        = s3_valid & s3_tag.produce;
  assign pop         = out_valid & out_ready;
  assign out_valid   = (fifo_count != '0);
  assign credit_used = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(s1_valid) +
                       (FIFO_AW+2)'(s2_valid) + (FIFO_AW+2)'(s3_valid);
  assign in_ready    = (credit_used < (FIFO_AW+2)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  // Head of the queue drives the result ports.
  assign head           = fifo_mem[rd_ptr];
  assign edge_magnitude = head.mag;
  assign direction_deg  = head.dir;
  assign out_column     = head.column;
  assign out_row        = head.row;
  assign last_of_image  = head.last;

endmodule

`default_nettype wire

@@ hw/rtl/sobel_checker.sv @@
// Port-level checks for the Sobel block, bound to its top level.
`default_nettype none

module sobel_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [7:0]        edge_magnitude,
  input wire logic signed [9:0] direction_deg,
  input wire logic [10:0]       out_column,
  input wire logic [15:0]       out_row,
  input wire logic              last_of_image
);

  // Out of reset the block is empty and ready for pixels.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_magnitude) &&
      $stable(direction_deg) && $stable(out_column) && $stable(out_row) &&
      $stable(last_of_image))
    else $error("stalled result beat changed");

  // Direction is always one of the nine 45 degree steps.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> direction_deg == -10'sd270 || direction_deg == -10'sd225 ||
      direction_deg == -10'sd180 || direction_deg == -10'sd135 ||
      direction_deg == -10'sd90 || direction_deg == -10'sd45 ||
      direction_deg == 10'sd0 || direction_deg == 10'sd45 ||
      direction_deg == 10'sd90)
    else $error("direction outside the quantized set");

endmodule

bind sobel_edge_magnitude_direction sobel_checker u_sobel_checker (.*);

`default_nettype wire

@@ sim/sobel_edge_magnitude_direction_tb.sv @@
// Self-checking testbench for the Sobel edge magnitude and direction block.
`timescale 1ns / 1ps

module sobel_edge_magnitude_direction_tb;
  import sobel_pkg::*;

  // Tracks the block's line stores, window and counters, and queues the edge results they imply.
  class edge_predictor;
    logic [7:0]  upper_line  [DEFAULT_MAX_WIDTH];
    logic [7:0]  middle_line [DEFAULT_MAX_WIDTH];
    logic [7:0]  win [9];
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    int unsigned column, row;
    res_t        pending_edges [$];
    int unsigned pixels, results, writes, errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = 8'h00;
        middle_line[i] = 8'h00;
      end
      foreach (win[i]) win[i] = 8'h00;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      column     = 0;
      row        = 0;
      pixels     = 0;
      results    = 0;
      writes     = 0;
      errors     = 0;
    endfunction

    // Widths outside the supported range are clamped by the block.
    function int unsigned width_of(logic [11:0] value);
      if (value < 3) return 3;
      if (value > DEFAULT_MAX_WIDTH) return DEFAULT_MAX_WIDTH;
      return value;
    endfunction

    function int unsigned eff_width();
      return width_of(width_reg);
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function int unsigned pending();
      return pending_edges.size();
    endfunction

    function bit at_frame_start();
      return column == 0 && row == 0;
    endfunction

    // Number of pixels that brings the counters back to the top left corner.
    function int unsigned pixels_to_frame_end();
      int unsigned w, h, c, r, n;
      w = eff_width();
      h = eff_height();
      c = column;
      r = row;
      n = 0;
      do begin
        n++;
        if (c + 1 >= w) begin
          c = 0;
          r = (r + 1 >= h) ? 0 : r + 1;
        end else begin
          c++;
        end
      end while (c != 0 || r != 0);
      return n;
    endfunction

    function void take_config(cfg_index_t idx, logic [15:0] value);
      writes++;
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = value[11:0];
        CFG_IMAGE_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    // Octant of the gradient, found by comparing against tan(22.5) and tan(67.5) in Q16.
    function int angle_sector(int a, int b);
      longint unsigned ax, by;
      int m;
      ax = (a < 0) ? -a : a;
      by = (b < 0) ? -b : b;
      if (by * 65536 < ax * TAN_LOW_Q16) m = 0;
      else if (by * 65536 > ax * TAN_HIGH_Q16) m = 2;
      else m = 1;
      if (b >= 0) return (a >= 0) ? m : 4 - m;
      return (a >= 0) ? -m : m - 4;
    endfunction

    function void take_pixel(logic [7:0] px);
      int unsigned w, h, c, r, mag;
      logic [7:0] up, mid;
      int t [9];
      int a, b, dir;
      res_t want;
      w = eff_width();
      h = eff_height();
      c = column;
      r = row;
      up = 8'h00;
      mid = 8'h00;
      pixels++;

      // Line stores shift down by one line at this column.
      if (c < DEFAULT_MAX_WIDTH) begin
        up  = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = px;
      end

      // Window shifts left and takes the new column.
      for (int i = 0; i < 3; i++) begin
        win[i * 3]     = win[i * 3 + 1];
        win[i * 3 + 1] = win[i * 3 + 2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;

      // Interior pixels inside the current image size produce a result.
      if (c >= 2 && r >= 2 && c < w && r < h) begin
        foreach (t[i]) t[i] = win[i];
        a = (t[6] + 2 * t[7] + t[8]) - (t[0] + 2 * t[1] + t[2]);
        b = (t[2] + 2 * t[5] + t[8]) - (t[0] + 2 * t[3] + t[6]);
        mag = (((a < 0) ? -a : a) + ((b < 0) ? -b : b) + 2) >> 2;
        if (mag > 255) mag = 255;
        dir = (a != 0 || b != 0) ? angle_sector(a, b) * 45 - 90 : 0;
        want.mag    = mag[7:0];
        want.dir    = 10'(dir);
        want.column = 11'(c - 1);
        want.row    = 16'(r - 1);
        want.last   = (c == w - 1 && r == h - 1);
        pending_edges.push_back(want);
      end

      // Counters wrap at the end of a line and at the end of the image.
      if (c + 1 >= w) begin
        column = 0;
        row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        column = c + 1;
      end
    endfunction

    function void report(string field, logic signed [31:0] want, logic signed [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_edge(res_t got);
      res_t want;
      results++;
      if (pending_edges.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got magnitude %0d at row %0d column %0d",
                 $time, got.mag, got.row, got.column);
        return;
      end
      want = pending_edges.pop_front();
      if (got.mag !== want.mag) report("edge_magnitude", want.mag, got.mag);
      if (got.dir !== want.dir) report("direction_deg", want.dir, got.dir);
      if (got.column !== want.column) report("out_column", want.column, got.column);
      if (got.row !== want.row) report("out_row", want.row, got.row);
      if (got.last !== want.last) report("last_of_image", want.last, got.last);
    endfunction
  endclass

  localparam int          HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 800;

  // Index codes that select no register.
  localparam cfg_index_t CFG_SPARE_A = cfg_index_t'(2'd2);
  localparam cfg_index_t CFG_SPARE_B = cfg_index_t'(2'd3);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {PAT_NOISE, PAT_BINARY, PAT_RAMP, PAT_FLAT} pattern_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_index_t        cfg_index = CFG_IMAGE_WIDTH;
  logic [15:0]       cfg_data = 16'h0000;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        red_sample = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        edge_magnitude;
  logic signed [9:0] direction_deg;
  logic [10:0]       out_column;
  logic [15:0]       out_row;
  logic              last_of_image;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_on = 1'b0;

  edge_predictor edges;

  sobel_edge_magnitude_direction dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .red_sample     (red_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edge_magnitude (edge_magnitude),
    .direction_deg  (direction_deg),
    .out_column     (out_column),
    .out_row        (out_row),
    .last_of_image  (last_of_image)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : receiver_holdoff
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_on = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_on = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // Every accepted beat on each channel goes to the predictor.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) edges.take_config(cfg_index, cfg_data);
      if (in_valid && in_ready) edges.take_pixel(red_sample);
      if (out_valid && out_ready) begin
        edges.check_edge(res_t'({edge_magnitude, direction_deg, out_column, out_row,
                                 last_of_image}));
      end
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 48;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 48;
      end
      IDLE_BOTH: begin
        send_idle_pct = 35;
        recv_stall_pct = 35;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Entered and left at a falling edge; valid stays high when the caller sends again.
  task automatic send_pixel(input logic [7:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red_sample <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pattern_pixel(pattern_t pat, int unsigned i, int unsigned w,
                                               int base, int gx, int gy);
    case (pat)
      PAT_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      PAT_RAMP:   return 8'(base + gx * int'(i % w) + gy * int'(i / w));
      PAT_FLAT:   return 8'(base);
      default:    return 8'($urandom);
    endcase
  endfunction

  // Sends a run of pixels; optionally stops halfway until every result is back.
  task automatic send_stream(input int unsigned count, input pattern_t pat, input bit pause_mid);
    int base, gx, gy;
    int unsigned w, i;
    base = $urandom_range(255);
    gx = int'($urandom_range(80)) - 40;
    gy = int'($urandom_range(80)) - 40;
    w = edges.eff_width();
    for (i = 0; i < count; i++) begin
      if (pause_mid && i != 0 && i == count / 2) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (edges.pending() != 0);
      end
      send_pixel(pattern_pixel(pat, i, w, base, gx, gy));
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [15:0] width_value, input logic [15:0] height_value,
                              input bit spare, input bit height_first);
    if (height_first) begin
      write_reg(CFG_IMAGE_HEIGHT, height_value);
      write_reg(CFG_IMAGE_WIDTH, width_value);
    end else begin
      write_reg(CFG_IMAGE_WIDTH, width_value);
      write_reg(CFG_IMAGE_HEIGHT, height_value);
    end
    if (spare) write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Waits for all results, then lets the pipeline empty of pixels that make none.
  task automatic drain();
    while (edges.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] wv, hv;
    int unsigned count, phase, random_from;
    int gx, gy, r, c;
    edges = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: two lines and a few pixels of a 640 wide image.
    set_idle(IDLE_NONE);
    send_stream(2 * RESET_WIDTH + 5, PAT_NOISE, 1'b0);
    drain();

    // Undersized width and height shrink the image mid-line; masked upper width bits.
    set_geometry(16'hF001, 16'h0000, 1'b1, 1'b0);
    send_stream(edges.pixels_to_frame_end(), PAT_NOISE, 1'b0);
    drain();

    // Minimal images whose gradient points in each of the eight directions, or none.
    set_geometry(16'd3, 16'd3, 1'b0, 1'b1);
    for (gy = -1; gy <= 1; gy++) begin
      for (gx = -1; gx <= 1; gx++) begin
        for (r = 0; r < 3; r++) begin
          for (c = 0; c < 3; c++) begin
            send_pixel(8'(128 + 60 * gx * (c - 1) + 60 * gy * (r - 1)));
          end
        end
      end
    end
    // A hard corner saturates the magnitude.
    for (c = 0; c < 9; c++) send_pixel((c == 5 || c >= 7) ? 8'hFF : 8'h00);
    in_valid <= 1'b0;
    drain();

    // Tallest image, cut short by lowering the height below the current row.
    set_geometry(16'd3, 16'hFFFF, 1'b0, 1'b0);
    send_stream(15, PAT_BINARY, 1'b0);
    drain();
    set_geometry(16'd3, 16'd4, 1'b1, 1'b1);
    send_stream(edges.pixels_to_frame_end(), PAT_NOISE, 1'b0);
    drain();

    // Oversized width acts as the widest line.
    set_idle(IDLE_BOTH);
    set_geometry(16'hFFFF, 16'd3, 1'b0, 1'b0);
    send_stream(edges.pixels_to_frame_end(), PAT_NOISE, 1'b0);
    drain();

    // Receiver holds off long enough to back up the block while pixels keep coming.
    random_from = edges.pixels;
    set_idle(IDLE_NONE);
    set_geometry(16'd20, 16'd6, 1'b0, 1'b1);
    hold_req = 1'b1;
    send_stream(2 * edges.pixels_to_frame_end(), PAT_NOISE, 1'b0);

    // Random geometry and content, rotating through the idle modes.
    phase = 0;
    while (edges.pixels - random_from < RANDOM_ITEMS) begin
      drain();
      set_idle(idle_mode_t'(phase % 4));
      case ($urandom_range(15))
        0, 1:    wv = 16'($urandom_range(2));
        2:       wv = 16'($urandom_range(40, 17));
        default: wv = 16'($urandom_range(16, 3));
      endcase
      wv[15:12] = 4'($urandom);
      case ($urandom_range(15))
        0, 1:    hv = 16'($urandom_range(2));
        2:       hv = 16'($urandom_range(20, 9));
        default: hv = 16'($urandom_range(8, 3));
      endcase
      // Widening mid-image would read line store entries never written.
      if (!edges.at_frame_start() && edges.width_of(wv[11:0]) > edges.eff_width()) begin
        wv[11:0] = 12'(edges.eff_width());
      end
      set_geometry(wv, hv, $urandom_range(3) == 0, $urandom_range(1));
      count = edges.pixels_to_frame_end()
            + $urandom_range(1) * edges.eff_width() * edges.eff_height();
      if (count > 1 && $urandom_range(3) == 0) count = $urandom_range(count - 1, 1);
      send_stream(count, pattern_t'($urandom_range(3)), phase % 3 == 1);
      phase++;
    end

    // Final drain and verdict.
    while (edges.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Run covered %0d pixel beats, %0d result beats and %0d register writes,",
             edges.pixels, edges.results, edges.writes);
    $display("with images from 3x3 up to 2048 columns under four sender and receiver idle modes.");
    if (edges.errors == 0 && edges.pending() == 0) begin
      $display("sobel_edge_magnitude_direction_tb OK");
    end else begin
      $display("sobel_edge_magnitude_direction_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, edges.pending());
    $display("sobel_edge_magnitude_direction_tb NOT OK");
    $finish;
  end

endmodule
